// ----- rtl/core/dctm_pkg.sv -----
package dctm_pkg;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_TILE_SIZE    = 2'd2
   } reg_index_type;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int COORD_WIDTH    = 12;
   localparam int SIZE_WIDTH     = 13;
   localparam int TILE_WIDTH     = 7;
   localparam int PIX_WIDTH      = 8;

   localparam logic [SIZE_WIDTH-1:0] MAX_HEIGHT   = 13'd4096;
   localparam logic [SIZE_WIDTH-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [SIZE_WIDTH-1:0] RESET_HEIGHT = 13'd480;
   localparam logic [TILE_WIDTH-1:0] RESET_TILE   = 7'd10;

   // packed so that tile_min sits in the lowest bits
   typedef struct packed {
      logic                   frame_done;
      logic [COORD_WIDTH-1:0] tile_col;
      logic [COORD_WIDTH-1:0] tile_row;
      logic [PIX_WIDTH-1:0]   tile_min;
   } rsp_type;

endpackage

// ----- rtl/core/dark_channel_tile_minimum.sv -----
// a pixel that closes a tile goes through the update stage into the result queue
// throughput: one pixel per cycle while not stalled, set by one read-modify-write
// of the tile column memory per pixel, with forwarding between consecutive pixels
// of the same column; a two-entry result queue decouples the stream from output
// backpressure; reset: synchronous, clears position counters and the queue;
// registers take 640 x 480 with 10-pixel tiles; the column memory is not cleared
module dark_channel_tile_minimum import dctm_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_TILE  = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,   // blue, green, red
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // tile_min, tile_row, tile_col
   output logic                      rsp_tlast,   // frame_done
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int TW  = $clog2(MAX_TILE);
   localparam int TSW = $clog2(MAX_TILE + 1);

   // configuration registers
   logic [SIZE_WIDTH-1:0] width_ff;
   logic [SIZE_WIDTH-1:0] height_ff;
   logic [TILE_WIDTH-1:0] tile_size_ff;
   logic                  csr_write;
   logic                  restart;
   reg_index_type         csr_index;

   // effective sizes
   logic [CW:0]           w_eff;
   logic [SIZE_WIDTH-1:0] h_eff;
   logic [TSW-1:0]        t_eff;

   // position counters
   logic [CW-1:0]          pix_col_ff, pix_col_in;
   logic [COORD_WIDTH-1:0] pix_row_ff, pix_row_in;
   logic [TW-1:0]          col_in_tile_ff, col_in_tile_in;
   logic [TW-1:0]          row_in_tile_ff, row_in_tile_in;
   logic [CW-1:0]          tile_col_ff, tile_col_in;
   logic [COORD_WIDTH-1:0] tile_row_ff, tile_row_in;

   logic                 accept;
   logic                 last_col;
   logic                 last_row;
   logic                 col_wrap;
   logic                 row_wrap;
   logic [PIX_WIDTH-1:0] blue, green, red;
   logic [PIX_WIDTH-1:0] pix_min;

   // tile column memory
   logic [PIX_WIDTH-1:0] mem [MAX_WIDTH];
   logic [PIX_WIDTH-1:0] rd_data_ff;

   // update stage
   logic                   s1_valid_ff;
   logic [CW-1:0]          s1_slot_ff;
   logic [PIX_WIDTH-1:0]   s1_pix_ff;
   logic                   s1_first_ff;
   logic                   s1_emit_ff;
   logic [COORD_WIDTH-1:0] s1_tile_row_ff;
   logic                   s1_frame_done_ff;
   logic [PIX_WIDTH-1:0]   old_min;
   logic [PIX_WIDTH-1:0]   new_min;

   // forwarding of the write done in the previous cycle
   logic                 fwd_valid_ff;
   logic [CW-1:0]        fwd_slot_ff;
   logic [PIX_WIDTH-1:0] fwd_data_ff;

   // result queue
   rsp_type    push_data;
   rsp_type    out_data;
   logic       push;
   logic       pop;
   logic [1:0] fifo_count;
   logic [2:0] load;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      restart = 1'b0;
      case (csr_index)
         REG_IMAGE_WIDTH:  restart = csr_write;
         REG_IMAGE_HEIGHT: restart = csr_write;
         REG_TILE_SIZE:    restart = csr_write;
         default:          restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RESET_WIDTH;
         height_ff    <= RESET_HEIGHT;
         tile_size_ff <= RESET_TILE;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff     <= csr_pwdata[SIZE_WIDTH-1:0];
            REG_IMAGE_HEIGHT: height_ff    <= csr_pwdata[SIZE_WIDTH-1:0];
            REG_TILE_SIZE:    tile_size_ff <= csr_pwdata[TILE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      case (csr_index)
         REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         REG_TILE_SIZE:    csr_prdata = 32'(tile_size_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   // clamped sizes
   always_comb begin
      if (width_ff == '0) begin
         w_eff = (CW+1)'(1);
      end else if (15'(width_ff) > 15'(MAX_WIDTH)) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(width_ff);
      end

      if (height_ff == '0) begin
         h_eff = 13'd1;
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end

      if (tile_size_ff == '0) begin
         t_eff = TSW'(1);
      end else if (10'(tile_size_ff) > 10'(MAX_TILE)) begin
         t_eff = TSW'(MAX_TILE);
      end else begin
         t_eff = TSW'(tile_size_ff);
      end
   end

   // pixel and position decode
   assign accept = req_tvalid & req_tready;
   assign blue   = req_tdata[7:0];
   assign green  = req_tdata[15:8];
   assign red    = req_tdata[23:16];

   always_comb begin
      pix_min = (blue < green) ? blue : green;
      if (red < pix_min) begin
         pix_min = red;
      end
   end

   assign last_col = ({1'b0, pix_col_ff} + (CW+1)'(1)) >= w_eff;
   assign last_row = ({1'b0, pix_row_ff} + 13'd1) >= h_eff;
   assign col_wrap = ({1'b0, col_in_tile_ff} + (TW+1)'(1)) >= (TW+1)'(t_eff);
   assign row_wrap = ({1'b0, row_in_tile_ff} + (TW+1)'(1)) >= (TW+1)'(t_eff);

   always_comb begin
      pix_col_in     = pix_col_ff;
      pix_row_in     = pix_row_ff;
      col_in_tile_in = col_in_tile_ff;
      row_in_tile_in = row_in_tile_ff;
      tile_col_in    = tile_col_ff;
      tile_row_in    = tile_row_ff;
      if (restart) begin
         pix_col_in     = '0;
         pix_row_in     = '0;
         col_in_tile_in = '0;
         row_in_tile_in = '0;
         tile_col_in    = '0;
         tile_row_in    = '0;
      end else if (accept) begin
         if (last_col) begin
            pix_col_in     = '0;
            col_in_tile_in = '0;
            tile_col_in    = '0;
            if (last_row) begin
               pix_row_in     = '0;
               row_in_tile_in = '0;
               tile_row_in    = '0;
            end else begin
               pix_row_in = pix_row_ff + 12'd1;
               if (row_wrap) begin
                  row_in_tile_in = '0;
                  tile_row_in    = tile_row_ff + 12'd1;
               end else begin
                  row_in_tile_in = row_in_tile_ff + TW'(1);
               end
            end
         end else begin
            pix_col_in = pix_col_ff + CW'(1);
            if (col_wrap) begin
               col_in_tile_in = '0;
               tile_col_in    = tile_col_ff + CW'(1);
            end else begin
               col_in_tile_in = col_in_tile_ff + TW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_col_ff     <= '0;
         pix_row_ff     <= '0;
         col_in_tile_ff <= '0;
         row_in_tile_ff <= '0;
         tile_col_ff    <= '0;
         tile_row_ff    <= '0;
      end else begin
         pix_col_ff     <= pix_col_in;
         pix_row_ff     <= pix_row_in;
         col_in_tile_ff <= col_in_tile_in;
         row_in_tile_ff <= row_in_tile_in;
         tile_col_ff    <= tile_col_in;
         tile_row_ff    <= tile_row_in;
      end
   end

   // memory read at acceptance, write back from the update stage
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[tile_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem[s1_slot_ff] <= new_min;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_slot_ff       <= tile_col_ff;
         s1_pix_ff        <= pix_min;
         s1_first_ff      <= (col_in_tile_ff == '0) && (row_in_tile_ff == '0);
         s1_emit_ff       <= (last_col | col_wrap) & (last_row | row_wrap);
         s1_tile_row_ff   <= tile_row_ff;
         s1_frame_done_ff <= last_col & last_row;
      end
      fwd_slot_ff <= s1_slot_ff;
      fwd_data_ff <= new_min;
   end

   always_comb begin
      old_min = (fwd_valid_ff && (fwd_slot_ff == s1_slot_ff)) ? fwd_data_ff : rd_data_ff;
      if (s1_first_ff || (s1_pix_ff < old_min)) begin
         new_min = s1_pix_ff;
      end else begin
         new_min = old_min;
      end
   end

   // result queue
   assign push                 = s1_valid_ff & s1_emit_ff;
   assign push_data.tile_min   = new_min;
   assign push_data.tile_row   = s1_tile_row_ff;
   assign push_data.tile_col   = COORD_WIDTH'(s1_slot_ff);
   assign push_data.frame_done = s1_frame_done_ff;

   assign pop        = rsp_tvalid & rsp_tready;
   assign load       = {1'b0, fifo_count} + {2'b00, push} - {2'b00, pop};
   assign req_tready = (load <= 3'd1);

   dctm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = out_data[31:0];
   assign rsp_tlast = out_data.frame_done;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pix_col_ff} < w_eff)
      else $error("pixel column beyond image width");

   a_tile_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      ((TW+1)'(col_in_tile_ff) < (TW+1)'(t_eff)) &&
      ((TW+1)'(row_in_tile_ff) < (TW+1)'(t_eff)))
      else $error("position inside tile beyond tile size");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_count != 2'd2) || pop)
      else $error("result pushed into a full queue");

   a_update_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction missing from update stage");

endmodule

// ----- rtl/core/dctm_rsp_fifo.sv -----
module dctm_rsp_fifo import dctm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   input  logic       out_ready,
   output logic       out_valid,
   output rsp_type    out_data,
   output logic [1:0] count
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
